// ===== rtl/core/ksat_pkg.sv =====
// Shared types and constants of the keyed saturating amount table.
// Holds the request and token structs passed between the top level and the cells.
// No dependencies.
`default_nettype none

package ksat_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 16;

  localparam logic [1:0] OP_MERGE  = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [63:0] AMOUNT_MAX = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  kind;
    logic [3:0]  subkind;
    logic [63:0] key;
    logic [63:0] amount;
  } req_t;

  typedef struct packed {
    logic        active;
    logic        matched;
    logic        free_seen;
    logic        removed;
    logic [63:0] rem_amount;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/ksat_cell.sv =====
// One slot of the table: key, amount and valid bit, plus the lookup token stage.
// Depends on ksat_pkg for req_t, tok_t and the opcode constants.
`default_nettype none

module ksat_cell import ksat_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire req_t req,
  input  wire tok_t tok_in,
  input  wire logic ins_go,
  output tok_t      tok_out,
  output logic      cand
);

  logic        valid_r;
  logic        cand_r;
  tok_t        tok_r;
  logic [3:0]  kind_r;
  logic [3:0]  subkind_r;
  logic [63:0] key_r;
  logic [63:0] amount_r;

  logic        hit;
  logic [64:0] cur_x;
  logic [64:0] amt_x;
  logic [64:0] opd_x;
  logic [64:0] sum_x;
  logic [63:0] sat;
  logic        gt;
  logic        frees;
  tok_t        tok_nxt;

  always_comb begin
    hit   = tok_in.active && valid_r && (kind_r == req.kind) &&
            (subkind_r == req.subkind) && (key_r == req.key);
    cur_x = {amount_r[63], amount_r};
    amt_x = {req.amount[63], req.amount};
    opd_x = (req.op == OP_REMOVE) ? (65'd0 - amt_x) : amt_x;
    sum_x = cur_x + opd_x;
    if (sum_x[64]) begin
      sat = 64'd0;
    end else if (sum_x[63]) begin
      sat = AMOUNT_MAX;
    end else begin
      sat = sum_x[63:0];
    end
    gt    = !sum_x[64] && (sum_x != 65'd0);
    frees = hit && (req.op == OP_REMOVE) && !gt;

    tok_nxt            = tok_in;
    tok_nxt.matched    = tok_in.matched || hit;
    tok_nxt.free_seen  = tok_in.free_seen || !valid_r;
    if (frees) begin
      tok_nxt.removed    = 1'b1;
      tok_nxt.rem_amount = amount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_in.active) begin
        cand_r <= !valid_r && !tok_in.free_seen;
      end else if (ins_go) begin
        cand_r <= 1'b0;
      end
      if (frees) begin
        valid_r <= 1'b0;
      end else if (ins_go && cand_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_go && cand_r) begin
      kind_r    <= req.kind;
      subkind_r <= req.subkind;
      key_r     <= req.key;
      amount_r  <= req.amount;
    end else if (hit) begin
      case (req.op)
        OP_MERGE:  amount_r <= sat;
        OP_SET:    amount_r <= req.amount;
        OP_REMOVE: if (gt) amount_r <= sat;
        default:   ;
      endcase
    end
  end

  assign tok_out = tok_r;
  assign cand    = cand_r;

endmodule

`default_nettype wire

// ===== rtl/core/keyed_saturating_amount_table_unit.sv =====
// Takes one item at a time: in_stall is high until the result of the last item is committed;
// the lookup token walks the chain of slot cells one cell per cycle, then the
// finish state commits the result once the output is not stalled.
// Reset (rst_n low, synchronous) empties the table and drops any item in flight.
// Top level of the keyed saturating amount table; depends on ksat_pkg, ksat_cell.
`default_nettype none

module keyed_saturating_amount_table_unit import ksat_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [3:0]         in_res_kind,
  input  wire logic [3:0]         in_res_subkind,
  input  wire logic [63:0]        in_key_id,
  input  wire logic signed [63:0] in_amount,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_accepted,
  output logic                    out_new_entry,
  output logic                    out_entry_removed,
  output logic signed [63:0]      out_removed_amount,
  output logic                    out_table_full
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   launch_r;
  req_t   req_r;
  tok_t   tail_r;

  tok_t                     tok [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] cand_vec;

  logic        out_valid_r;
  logic        accepted_r, new_entry_r, removed_r, full_r;
  logic [63:0] rem_amount_r;

  logic in_acc;
  logic out_free;
  logic commit;
  logic op_known;
  logic need_ins;
  logic ins_go;
  logic pos_amount;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_FINISH) && out_free;

  assign pos_amount = !req_r.amount[63] && (req_r.amount != 64'd0);
  assign op_known   = (req_r.op == OP_MERGE) || (req_r.op == OP_SET) ||
                      (req_r.op == OP_REMOVE);
  assign need_ins   = !tail_r.matched &&
                      ((req_r.op == OP_SET) || ((req_r.op == OP_MERGE) && pos_amount));
  assign ins_go     = commit && need_ins && tail_r.free_seen;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = launch_r;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ksat_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .tok_in  (tok[i]),
      .ins_go  (ins_go),
      .tok_out (tok[i+1]),
      .cand    (cand_vec[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:   if (tok[TABLE_ENTRIES].active) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.op      <= in_opcode;
      req_r.kind    <= in_res_kind;
      req_r.subkind <= in_res_subkind;
      req_r.key     <= in_key_id;
      req_r.amount  <= in_amount;
    end
    if ((state_r == ST_SCAN) && tok[TABLE_ENTRIES].active) begin
      tail_r <= tok[TABLE_ENTRIES];
    end
    if (commit) begin
      accepted_r   <= (tail_r.matched && op_known) || (need_ins && tail_r.free_seen);
      new_entry_r  <= need_ins && tail_r.free_seen && (req_r.op == OP_MERGE);
      removed_r    <= tail_r.removed;
      rem_amount_r <= tail_r.removed ? tail_r.rem_amount : 64'd0;
      full_r       <= need_ins && !tail_r.free_seen;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = accepted_r;
  assign out_new_entry      = new_entry_r;
  assign out_entry_removed  = removed_r;
  assign out_removed_amount = rem_amount_r;
  assign out_table_full     = full_r;

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[TABLE_ENTRIES].active |-> (state_r == ST_SCAN))
    else $error("token left the chain outside a scan");

  a_one_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> $onehot0(cand_vec))
    else $error("more than one cell claims the free slot");

  a_insert_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go |-> !tail_r.matched && $onehot(cand_vec))
    else $error("insert issued without exactly one free slot");

  a_full_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !(out_table_full && out_accepted))
    else $error("full table result also marked accepted");

endmodule

`default_nettype wire
